[rtl/brb_pkg.sv]
package brb_pkg;

  typedef logic [1:0] op_t;

  localparam op_t OP_PUT  = 2'd0;
  localparam op_t OP_PEEK = 2'd1;
  localparam op_t OP_POP  = 2'd2;

  localparam int unsigned LEN_W  = 7;
  localparam int unsigned BYTE_W = 8;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_REFUSED = 1'b1;

endpackage

[rtl/brb_ram.sv]
module brb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/byte_ring_buffer_top.sv]
// Put, pop and refused or empty peek: result in the output register the cycle after the request.
// Throughput for those: one request per cycle while the result side keeps up.
// Accepted peek of N bytes: via store read and output registers, one byte per cycle while the
// output keeps up, set by the single read port; no new request is taken until the last byte.
// Reset clears the write position, fill level and put tracking; byte store contents are not cleared.
module byte_ring_buffer_top
  import brb_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // request_length[6:0], first_of_request[7], data_byte[15:8]
  input  logic [1:0]  s_axis_tuser,  // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // read_byte[7:0], fill_level[14:8], zero[15]
  output logic [1:0]  m_axis_tuser,  // status[0], read_valid[1]
  output logic        m_axis_tlast
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_PEEK = 1'b1;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
    logic [AW:0] d;
    d = (AW+1)'(DEPTH);
    if (v >= d) begin
      return AW'(v - d);
    end
    return v[AW-1:0];
  endfunction

  logic              state_q, state_d;
  logic [AW-1:0]     wp_q, wp_d;
  logic [CW-1:0]     held_q, held_d;
  logic [LEN_W-1:0]  left_q, left_d;
  logic              rej_q, rej_d;
  logic [AW-1:0]     rd_pos_q, rd_pos_d;
  logic [CW-1:0]     iss_q, iss_d;
  logic [CW-1:0]     rem_q, rem_d;
  logic              pend_q, pend_d;

  logic              m_valid_q, m_valid_d;
  logic [15:0]       m_data_q, m_data_d;
  logic [1:0]        m_user_q, m_user_d;
  logic              m_last_q, m_last_d;

  op_t               op;
  logic [LEN_W-1:0]  len;
  logic              first;
  logic [BYTE_W-1:0] din;
  logic              acc, out_free;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [BYTE_W-1:0] rdata;

  logic [AW-1:0]     base, pend_len, a_pos;
  logic [7:0]        room;
  logic              st;

  assign op    = s_axis_tuser;
  assign len   = s_axis_tdata[6:0];
  assign first = s_axis_tdata[7];
  assign din   = s_axis_tdata[15:8];

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign acc           = s_axis_tvalid && s_axis_tready;

  assign room     = 8'(DEPTH) - 8'(held_q);
  assign pend_len = rej_q ? '0 : left_q[AW-1:0];
  assign a_pos    = wrap({1'b0, wp_q} + {1'b0, pend_len});

  brb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (din),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    held_d    = held_q;
    left_d    = left_q;
    rej_d     = rej_q;
    rd_pos_d  = rd_pos_q;
    iss_d     = iss_q;
    rem_d     = rem_q;
    pend_d    = pend_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    m_last_d  = m_last_q;
    we        = 1'b0;
    waddr     = wp_q;
    re        = 1'b0;
    raddr     = rd_pos_q;
    base      = wp_q;
    st        = ST_REFUSED;

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (op)
            OP_PUT: begin
              if (first) begin
                if (left_q != '0 && !rej_q) begin
                  base = wrap({1'b0, wp_q} + {1'b0, left_q[AW-1:0]});
                end
                wp_d   = base;
                rej_d  = 1'b0;
                left_d = '0;
                if ({1'b0, len} > room) begin
                  rej_d  = 1'b1;
                  left_d = len - 1'b1;
                  st     = ST_REFUSED;
                end else if (len == '0) begin
                  st = ST_OK;
                end else begin
                  held_d = CW'(8'(held_q) + 8'(len));
                  we     = 1'b1;
                  waddr  = base;
                  wp_d   = wrap({1'b0, base} + (AW+1)'(1));
                  left_d = len - 1'b1;
                  st     = ST_OK;
                end
              end else if (left_q == '0) begin
                st = ST_REFUSED;
              end else if (rej_q) begin
                left_d = left_q - 1'b1;
                if (left_q == LEN_W'(1)) begin
                  rej_d = 1'b0;
                end
                st = ST_REFUSED;
              end else begin
                we     = 1'b1;
                waddr  = wp_q;
                wp_d   = wrap({1'b0, wp_q} + (AW+1)'(1));
                left_d = left_q - 1'b1;
                st     = ST_OK;
              end
            end
            OP_PEEK: begin
              if (8'(len) > 8'(held_q)) begin
                st = ST_REFUSED;
              end else if (len == '0) begin
                st = ST_OK;
              end else begin
                state_d  = S_PEEK;
                rd_pos_d = wrap(AW'(0) + {1'b0, a_pos} + (AW+1)'(DEPTH) - (AW+1)'(held_q));
                iss_d    = CW'(len);
                rem_d    = CW'(len);
                pend_d   = 1'b0;
                st       = ST_OK;
              end
            end
            OP_POP: begin
              if (8'(len) > 8'(held_q)) begin
                st = ST_REFUSED;
              end else begin
                held_d = held_q - CW'(len);
                st     = ST_OK;
              end
            end
            default: begin
              st = ST_REFUSED;
            end
          endcase
          if (!(op == OP_PEEK && st == ST_OK && len != '0)) begin
            m_valid_d = 1'b1;
            m_data_d  = {1'b0, 7'(held_d), 8'd0};
            m_user_d  = {1'b0, st};
            m_last_d  = 1'b1;
          end
        end
      end
      S_PEEK: begin
        re     = (iss_q != '0) && (!pend_q || out_free);
        raddr  = rd_pos_q;
        if (re) begin
          rd_pos_d = wrap({1'b0, rd_pos_q} + (AW+1)'(1));
          iss_d    = iss_q - 1'b1;
        end
        pend_d = re || (pend_q && !out_free);
        if (pend_q && out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {1'b0, 7'(held_q), rdata};
          m_user_d  = {1'b1, ST_OK};
          m_last_d  = (rem_q == CW'(1));
          rem_d     = rem_q - 1'b1;
          if (rem_q == CW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      wp_q      <= '0;
      held_q    <= '0;
      left_q    <= '0;
      rej_q     <= 1'b0;
      iss_q     <= '0;
      rem_q     <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      held_q    <= held_d;
      left_q    <= left_d;
      rej_q     <= rej_d;
      iss_q     <= iss_d;
      rem_q     <= rem_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_pos_q <= rd_pos_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

endmodule
